/* sv/fhas_pkg.sv */
package fhas_pkg;

  localparam int unsigned SAMPLE_W = 16;
  localparam int unsigned COEF_W   = 18;
  localparam int unsigned OUT_W    = 18;
  localparam int unsigned NCOEF    = 7;
  localparam int unsigned APB_DW   = 32;
  localparam int unsigned APB_AW   = 5;
  localparam int unsigned REG_IDX_W = 3;

  localparam logic [REG_IDX_W-1:0] REG_CENTER_GAIN = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_COEF_FIRST  = 3'd1;

  localparam logic signed [COEF_W-1:0] CENTER_GAIN_RST = 18'sd65536;

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;
  typedef logic signed [OUT_W-1:0]    out_t;

  typedef struct packed {
    logic load;
    logic mul;
    logic acc;
    logic acc_real;
    logic publish;
  } ctrl_cmd_t;

endpackage

/* sv/fhas_in_if.sv */
interface fhas_in_if;
  logic              valid;
  logic              ready;
  fhas_pkg::sample_t sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink (input valid, input sample_in, output ready);
endinterface

/* sv/fhas_out_if.sv */
interface fhas_out_if;
  logic           valid;
  logic           ready;
  fhas_pkg::out_t real_out;
  fhas_pkg::out_t imag_out;

  modport source (output valid, output real_out, output imag_out, input ready);
  modport sink (input valid, input real_out, input imag_out, output ready);
endinterface

/* sv/fhas_regs.sv */
module fhas_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fhas_pkg::APB_AW-1:0]   paddr,
  input  logic [fhas_pkg::APB_DW-1:0]   pwdata,
  output logic [fhas_pkg::APB_DW-1:0]   prdata,
  output logic                          pready,
  output fhas_pkg::coef_t               center_gain_o,
  output fhas_pkg::coef_t               coef_o [fhas_pkg::NCOEF]
);

  fhas_pkg::coef_t                   center_gain_q;
  fhas_pkg::coef_t                   coef_q [fhas_pkg::NCOEF];
  logic [fhas_pkg::REG_IDX_W-1:0]    idx;
  logic [fhas_pkg::REG_IDX_W-1:0]    coef_idx;
  logic                              wr_en;
  fhas_pkg::coef_t                   rd_val;

  assign idx      = paddr[fhas_pkg::APB_AW-1:2];
  assign coef_idx = idx - fhas_pkg::REG_COEF_FIRST;
  assign wr_en    = psel && penable && pwrite;
  assign pready   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      center_gain_q <= fhas_pkg::CENTER_GAIN_RST;
      for (int i = 0; i < fhas_pkg::NCOEF; i++) begin
        coef_q[i] <= '0;
      end
    end else if (wr_en) begin
      if (idx == fhas_pkg::REG_CENTER_GAIN) begin
        center_gain_q <= pwdata[fhas_pkg::COEF_W-1:0];
      end else begin
        coef_q[coef_idx] <= pwdata[fhas_pkg::COEF_W-1:0];
      end
    end
  end

  always_comb begin
    if (idx == fhas_pkg::REG_CENTER_GAIN) begin
      rd_val = center_gain_q;
    end else begin
      rd_val = coef_q[coef_idx];
    end
  end

  assign prdata = {{(fhas_pkg::APB_DW - fhas_pkg::COEF_W){rd_val[fhas_pkg::COEF_W-1]}}, rd_val};

  assign center_gain_o = center_gain_q;
  assign coef_o        = coef_q;

endmodule

/* sv/fhas_ctrl.sv */
module fhas_ctrl #(
  parameter int unsigned NSTEP = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output fhas_pkg::ctrl_cmd_t   cmd_o
);

  localparam int unsigned CNT_W = $clog2(NSTEP);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NSTEP - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MUL  = 2'd1;
  localparam logic [1:0] S_ACC  = 2'd2;
  localparam logic [1:0] S_OUT  = 2'd3;

  logic [1:0]       state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             acc_q, acc_real_q;
  logic             out_valid_q, out_valid_d;
  logic             out_free;
  logic             accept;

  assign out_free = !out_valid_q || out_ready_i;
  assign accept   = in_valid_i && (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    cmd_o   = '0;
    cmd_o.acc      = acc_q;
    cmd_o.acc_real = acc_real_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          cnt_d      = '0;
          state_d    = S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        if (cnt_q == CNT_LAST) begin
          state_d = S_ACC;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      S_ACC: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.publish = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.publish) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      acc_q       <= 1'b0;
      acc_real_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      acc_q       <= cmd_o.mul;
      acc_real_q  <= cmd_o.mul && (cnt_q == '0);
      out_valid_q <= out_valid_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  a_publish_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.publish |-> out_free)
    else $error("result written over a pending item");

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MUL) && (cnt_q == '0))
    else $error("accepted item did not start the sweep");

  a_mul_then_acc: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mul |=> cmd_o.acc)
    else $error("product not accumulated");

  a_real_first: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_real |-> $past(cmd_o.mul) && $past(state_q) == S_MUL && $past(cnt_q) == '0)
    else $error("real product out of order");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_MUL) |-> (cnt_q <= CNT_LAST))
    else $error("step counter overran");

endmodule

/* sv/fhas_dp.sv */
module fhas_dp #(
  parameter int unsigned TAPS  = 31,
  parameter int unsigned NSTEP = 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  fhas_pkg::ctrl_cmd_t   cmd_i,
  input  fhas_pkg::sample_t     sample_i,
  input  fhas_pkg::coef_t       center_gain_i,
  input  fhas_pkg::coef_t       coef_i [fhas_pkg::NCOEF],
  output fhas_pkg::out_t        real_o,
  output fhas_pkg::out_t        imag_o
);

  localparam int unsigned HALF   = (TAPS - 1) / 2;
  localparam int unsigned OPND_W = fhas_pkg::SAMPLE_W + 1;
  localparam int unsigned PROD_W = fhas_pkg::COEF_W + OPND_W;
  localparam int unsigned RND_W  = PROD_W - 16;
  localparam int unsigned ACC_W  = RND_W + 3;

  typedef struct packed {
    logic signed [fhas_pkg::COEF_W-1:0] coef;
    logic signed [OPND_W-1:0]           opnd;
  } work_t;

  fhas_pkg::sample_t        line_q [TAPS];
  work_t                    work_q [NSTEP];
  logic signed [PROD_W-1:0] prod_q;
  logic signed [PROD_W-1:0] rnd_full;
  logic signed [RND_W-1:0]  rnd;
  logic signed [RND_W-1:0]  real_acc_q;
  logic signed [ACC_W-1:0]  imag_acc_q;
  fhas_pkg::out_t           real_out_q;
  fhas_pkg::out_t           imag_out_q;

  function automatic fhas_pkg::out_t sat_out(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = ACC_W'(131071);
    lo = -ACC_W'(131072);
    if (v > hi) begin
      sat_out = 18'sh1FFFF;
    end else if (v < lo) begin
      sat_out = 18'sh20000;
    end else begin
      sat_out = v[fhas_pkg::OUT_W-1:0];
    end
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < TAPS; i++) begin
        line_q[i] <= '0;
      end
    end else if (cmd_i.load) begin
      for (int i = 0; i < TAPS - 1; i++) begin
        line_q[i] <= line_q[i+1];
      end
      line_q[TAPS-1] <= sample_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      work_q[0].coef <= center_gain_i;
      work_q[0].opnd <= {line_q[HALF][fhas_pkg::SAMPLE_W-1], line_q[HALF]};
      for (int k = 1; k < NSTEP; k++) begin
        work_q[k].coef <= coef_i[k-1];
        work_q[k].opnd <=
          {line_q[HALF-(2*k-1)][fhas_pkg::SAMPLE_W-1], line_q[HALF-(2*k-1)]} -
          {line_q[HALF+(2*k-1)][fhas_pkg::SAMPLE_W-1], line_q[HALF+(2*k-1)]};
      end
    end else if (cmd_i.mul) begin
      for (int k = 0; k < NSTEP - 1; k++) begin
        work_q[k] <= work_q[k+1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= work_q[0].coef * work_q[0].opnd;
    end
  end

  // half-up rounding then floor shift
  assign rnd_full = prod_q + PROD_W'(32768);
  assign rnd      = rnd_full[PROD_W-1:16];

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      imag_acc_q <= '0;
    end else if (cmd_i.acc) begin
      if (cmd_i.acc_real) begin
        real_acc_q <= rnd;
      end else begin
        imag_acc_q <= imag_acc_q + {{(ACC_W - RND_W){rnd[RND_W-1]}}, rnd};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      real_out_q <= sat_out({{(ACC_W - RND_W){real_acc_q[RND_W-1]}}, real_acc_q});
      imag_out_q <= sat_out(imag_acc_q);
    end
  end

  assign real_o = real_out_q;
  assign imag_o = imag_out_q;

endmodule

/* sv/fir_hilbert_analytic_signal.sv */
// FIR Hilbert transformer giving an analytic signal from a real sample stream.
// in_i takes one signed 16-bit sample per item; out_o gives one item with the
// real part (centre tap times center_gain) and the imaginary part (odd-distance
// antisymmetric sum), both rounded half-up and saturated to 18 bits.
// Coefficients are written over the APB port at byte address 4*index.
// The accepting cycle loads the delay line and the operands. The shared
// 18x17 multiplier then forms one product per step (centre tap plus each
// used distance), the last product is accumulated and the output register
// is written. The next item is accepted in the cycle after the result is
// written, so a new sample is not taken while the multiplier sweep runs.
// The result sits in an output register; new items are taken while it waits.
// If the receiver stalls, a finished sum waits until the register is free.
// Reset clears the delay line, sets center_gain to 1.0 and the other
// coefficients to zero, and empties the output register.
module fir_hilbert_analytic_signal #(
  parameter int unsigned TAPS = 31
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  fhas_in_if.sink                       in_i,
  fhas_out_if.source                    out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fhas_pkg::APB_AW-1:0]   paddr,
  input  logic [fhas_pkg::APB_DW-1:0]   pwdata,
  output logic [fhas_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);

  localparam int unsigned NUSED = ((TAPS - 1) / 4 > fhas_pkg::NCOEF) ?
                                  fhas_pkg::NCOEF : (TAPS - 1) / 4;
  localparam int unsigned NSTEP = NUSED + 1;

  fhas_pkg::coef_t     center_gain;
  fhas_pkg::coef_t     coef [fhas_pkg::NCOEF];
  fhas_pkg::ctrl_cmd_t cmd;

  fhas_regs u_regs (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .center_gain_o (center_gain),
    .coef_o        (coef)
  );

  fhas_ctrl #(
    .NSTEP (NSTEP)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  fhas_dp #(
    .TAPS  (TAPS),
    .NSTEP (NSTEP)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sample_i      (in_i.sample_in),
    .center_gain_i (center_gain),
    .coef_i        (coef),
    .real_o        (out_o.real_out),
    .imag_o        (out_o.imag_out)
  );

endmodule

/* tb/sv/tb.sv */
module tb;

  localparam int unsigned TAPS = 31;
  localparam int unsigned CENTER = (TAPS - 1) / 2;
  localparam int unsigned USED_DIST = ((TAPS - 1) / 4 < fhas_pkg::NCOEF) ?
                                      (TAPS - 1) / 4 : fhas_pkg::NCOEF;
  localparam int unsigned LATENCY = (TAPS - 1) / 4 + 4;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned PRESSURE_HOLD = 300;
  localparam int unsigned IDX_W = fhas_pkg::REG_IDX_W;
  localparam longint OUT_HI = 131071;
  localparam longint OUT_LO = -131072;

  typedef struct packed {
    fhas_pkg::out_t re;
    fhas_pkg::out_t im;
  } analytic_t;

  logic clk;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [fhas_pkg::APB_AW-1:0] paddr;
  logic [fhas_pkg::APB_DW-1:0] pwdata;
  logic [fhas_pkg::APB_DW-1:0] prdata;
  logic pready;

  fhas_in_if in_if ();
  fhas_out_if out_if ();

  fir_hilbert_analytic_signal #(
    .TAPS(TAPS)
  ) i_dut (
    .clk_i  (clk),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready)
  );

  fhas_pkg::coef_t gain_q;
  fhas_pkg::coef_t dist_q[fhas_pkg::NCOEF];
  fhas_pkg::sample_t taps_q[TAPS];
  analytic_t analytic_q[$];
  int mismatches = 0;
  int results_seen = 0;
  bit tx_gaps = 1'b0;
  bit rx_gaps = 1'b0;
  int rx_hold_req = 0;

  initial clk = 1'b0;
  always #5 clk = ~clk;

  function automatic longint round_q16(input longint p);
    return (p + 64'sd32768) >>> 16;
  endfunction

  function automatic fhas_pkg::out_t sat18(input longint v);
    if (v > OUT_HI) return fhas_pkg::out_t'(OUT_HI);
    if (v < OUT_LO) return fhas_pkg::out_t'(OUT_LO);
    return fhas_pkg::out_t'(v);
  endfunction

  // mostly back-to-back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  function automatic fhas_pkg::coef_t rand_coef();
    return fhas_pkg::coef_t'($urandom_range(262143));
  endfunction

  function automatic fhas_pkg::sample_t rand_sample(input int extreme_pct);
    int r;
    r = $urandom_range(99);
    if (r < extreme_pct) begin
      case ($urandom_range(3))
        0: return fhas_pkg::sample_t'(16'sh7fff);
        1: return fhas_pkg::sample_t'(16'sh8000);
        2: return fhas_pkg::sample_t'(16'sh0000);
        default: return fhas_pkg::sample_t'(16'shffff);
      endcase
    end
    if (r < extreme_pct + 20) return fhas_pkg::sample_t'($signed($urandom_range(15)) - 8);
    return fhas_pkg::sample_t'($urandom);
  endfunction

  // predictor and result checker
  always @(posedge clk or negedge rst_ni) begin
    logic [fhas_pkg::REG_IDX_W-1:0] idx;
    longint re_acc;
    longint im_acc;
    analytic_t want;
    if (!rst_ni) begin
      gain_q = fhas_pkg::CENTER_GAIN_RST;
      for (int i = 0; i < fhas_pkg::NCOEF; i++) dist_q[i] = '0;
      for (int i = 0; i < TAPS; i++) taps_q[i] = '0;
      analytic_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        idx = paddr[fhas_pkg::APB_AW-1:2];
        if (idx == fhas_pkg::REG_CENTER_GAIN) begin
          gain_q = fhas_pkg::coef_t'(pwdata[fhas_pkg::COEF_W-1:0]);
        end else begin
          dist_q[idx - fhas_pkg::REG_COEF_FIRST] =
            fhas_pkg::coef_t'(pwdata[fhas_pkg::COEF_W-1:0]);
        end
      end
      if (in_if.valid && in_if.ready) begin
        re_acc = round_q16(longint'(gain_q) * longint'(taps_q[CENTER]));
        im_acc = 0;
        for (int d = 0; d < USED_DIST; d++) begin
          im_acc += round_q16(longint'(dist_q[d]) *
                              (longint'(taps_q[CENTER - 2 * d - 1]) -
                               longint'(taps_q[CENTER + 2 * d + 1])));
        end
        for (int i = 0; i < TAPS - 1; i++) taps_q[i] = taps_q[i + 1];
        taps_q[TAPS - 1] = in_if.sample_in;
        analytic_q.push_back('{re: sat18(re_acc), im: sat18(im_acc)});
      end
      if (out_if.valid && out_if.ready) begin
        results_seen++;
        if (analytic_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("item %0d: unexpected result real %0d imag %0d",
                     results_seen, out_if.real_out, out_if.imag_out);
          end
        end else begin
          want = analytic_q.pop_front();
          if (out_if.real_out !== want.re || out_if.imag_out !== want.im) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("item %0d: real exp %0d got %0d, imag exp %0d got %0d",
                       results_seen, want.re, out_if.real_out, want.im, out_if.imag_out);
            end
          end
        end
      end
    end
  end

  // no-progress watchdog
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < STALL_LIMIT) begin
      @(posedge clk);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
          (psel && penable && pwrite && pready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
    $display("fir_hilbert_analytic_signal verification failed");
    $finish;
  end

  // result receiver
  initial begin
    int stall;
    out_if.ready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rx_hold_req != 0) begin
        stall = rx_hold_req;
        rx_hold_req = 0;
      end
      if (stall == 0 && rx_gaps) stall = pick_gap();
      if (stall != 0) begin
        out_if.ready <= 1'b0;
        stall--;
      end else begin
        out_if.ready <= rst_ni;
      end
    end
  end

  task automatic send_sample(input fhas_pkg::sample_t s);
    int gap;
    in_if.valid <= 1'b1;
    in_if.sample_in <= s;
    do @(posedge clk); while (!(in_if.valid && in_if.ready));
    @(negedge clk);
    gap = tx_gaps ? pick_gap() : 0;
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      in_if.sample_in <= fhas_pkg::sample_t'($urandom);
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (analytic_q.size() != 0) @(negedge clk);
    repeat (LATENCY + 5) @(negedge clk);
  endtask

  task automatic apb_write(input logic [fhas_pkg::REG_IDX_W-1:0] idx,
                           input fhas_pkg::coef_t value);
    logic [fhas_pkg::APB_DW-1:0] word;
    word = $urandom;
    word[fhas_pkg::COEF_W-1:0] = value;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= word;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(negedge clk);
  endtask

  task automatic program_filter(input fhas_pkg::coef_t gain,
                                input fhas_pkg::coef_t weights[fhas_pkg::NCOEF]);
    wait_idle();
    apb_write(fhas_pkg::REG_CENTER_GAIN, gain);
    for (int i = 0; i < fhas_pkg::NCOEF; i++) begin
      apb_write(IDX_W'(fhas_pkg::REG_COEF_FIRST + i), weights[i]);
    end
  endtask

  task automatic run_samples(input int count, input int extreme_pct);
    for (int i = 0; i < count; i++) send_sample(rand_sample(extreme_pct));
  endtask

  task automatic test_reset_defaults();
    send_sample(fhas_pkg::sample_t'(16'sh7fff));
    send_sample(fhas_pkg::sample_t'(16'sh8000));
    send_sample(fhas_pkg::sample_t'(16'shffff));
    send_sample(fhas_pkg::sample_t'(16'sh0001));
  endtask

  task automatic test_coef_extremes();
    fhas_pkg::coef_t weights[fhas_pkg::NCOEF];
    for (int i = 0; i < fhas_pkg::NCOEF; i++) weights[i] = fhas_pkg::coef_t'(-131072);
    program_filter(fhas_pkg::coef_t'(131071), weights);
    for (int i = 0; i < 8; i++) begin
      send_sample(i[0] ? fhas_pkg::sample_t'(16'sh8000) : fhas_pkg::sample_t'(16'sh7fff));
    end
    for (int i = 0; i < fhas_pkg::NCOEF; i++) weights[i] = fhas_pkg::coef_t'(131071);
    program_filter(fhas_pkg::coef_t'(-131072), weights);
    for (int i = 0; i < 8; i++) begin
      send_sample(i[1] ? fhas_pkg::sample_t'(16'sh8000) : fhas_pkg::sample_t'(16'sh7fff));
    end
  endtask

  // gain back to unity so the delayed centre tap shows on the real part
  task automatic test_reset_line();
    fhas_pkg::coef_t weights[fhas_pkg::NCOEF];
    for (int i = 0; i < fhas_pkg::NCOEF; i++) weights[i] = '0;
    program_filter(fhas_pkg::CENTER_GAIN_RST, weights);
    rx_gaps = 1'b1;
    run_samples(60, 30);
  endtask

  task automatic test_random_full_range();
    fhas_pkg::coef_t weights[fhas_pkg::NCOEF];
    wait_idle();
    test_reset_line();
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    for (int i = 0; i < fhas_pkg::NCOEF; i++) weights[i] = rand_coef();
    program_filter(rand_coef(), weights);
    run_samples(150, 10);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    for (int i = 0; i < fhas_pkg::NCOEF; i++) weights[i] = rand_coef();
    program_filter(rand_coef(), weights);
    run_samples(150, 10);
  endtask

  task automatic test_saturation_max();
    fhas_pkg::coef_t weights[fhas_pkg::NCOEF];
    for (int i = 0; i < fhas_pkg::NCOEF; i++) weights[i] = fhas_pkg::coef_t'(131071);
    program_filter(fhas_pkg::coef_t'(131071), weights);
    tx_gaps = 1'b1;
    rx_gaps = 1'b1;
    run_samples(220, 70);
  endtask

  task automatic test_saturation_min();
    fhas_pkg::coef_t weights[fhas_pkg::NCOEF];
    for (int i = 0; i < fhas_pkg::NCOEF; i++) weights[i] = fhas_pkg::coef_t'(-131072);
    program_filter(fhas_pkg::coef_t'(-131072), weights);
    tx_gaps = 1'b0;
    rx_gaps = 1'b1;
    run_samples(220, 70);
  endtask

  task automatic test_small_coefs();
    fhas_pkg::coef_t weights[fhas_pkg::NCOEF];
    for (int i = 0; i < fhas_pkg::NCOEF; i++) begin
      weights[i] = fhas_pkg::coef_t'($signed($urandom_range(4095)) - 2048);
    end
    program_filter(fhas_pkg::coef_t'($signed($urandom_range(4095)) - 2048), weights);
    tx_gaps = 1'b1;
    rx_gaps = 1'b0;
    run_samples(220, 10);
  endtask

  task automatic test_output_backpressure();
    fhas_pkg::coef_t weights[fhas_pkg::NCOEF];
    for (int i = 0; i < fhas_pkg::NCOEF; i++) weights[i] = rand_coef();
    program_filter(rand_coef(), weights);
    tx_gaps = 1'b0;
    rx_gaps = 1'b0;
    rx_hold_req = PRESSURE_HOLD;
    run_samples(60, 20);
    rx_gaps = 1'b1;
  endtask

  initial begin
    rst_ni = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.sample_in = '0;
    repeat (8) @(negedge clk);
    rst_ni = 1'b1;
    @(negedge clk);
    test_reset_defaults();
    test_coef_extremes();
    test_random_full_range();
    test_saturation_max();
    test_saturation_min();
    test_small_coefs();
    test_output_backpressure();
    wait_idle();
    if (mismatches == 0) begin
      $display("fir_hilbert_analytic_signal verification clean");
    end else begin
      $display("fir_hilbert_analytic_signal verification failed");
    end
    $finish;
  end

endmodule
